@@ src/urpc_pkg.sv @@
// ----------------------------------------------------------------------------
// urpc_pkg
// Shared types and constants for the ultrasonic ranging / motor PWM controller.
// ----------------------------------------------------------------------------
`default_nettype none

package urpc_pkg;

  // default widths of the echo counter and of the pwm duty / counter
  localparam int ECHO_COUNT_BITS_DEF = 16;
  localparam int DUTY_BITS_DEF       = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIST_W     = 17;
  localparam int TICK_W     = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_WAIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q16     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CM        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CM        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP       = 3'd5;

  // configuration reset values
  localparam logic [9:0]  TRIGGER_WIDTH_RST = 10'd10;
  localparam logic [15:0] GUARD_WAIT_RST    = 16'd1000;
  localparam logic [15:0] SCALE_Q16_RST     = 16'd2228;
  localparam logic [8:0]  MIN_CM_RST        = 9'd2;
  localparam logic [8:0]  MAX_CM_RST        = 9'd400;
  localparam logic [11:0] PWM_TOP_RST       = 12'd2399;

  // distance thresholds in q8 cm
  localparam logic [DIST_W-1:0] NEAR_Q8 = 17'd12800;  // 50 cm
  localparam logic [DIST_W-1:0] MID_Q8  = 17'd25600;  // 100 cm
  localparam logic [DIST_W-1:0] FAR_Q8  = 17'd51200;  // 200 cm

  // duty values, cut down to the duty width where used
  localparam logic [15:0] DUTY_NEAR = 16'd99;
  localparam logic [15:0] DUTY_MID  = 16'd399;
  localparam logic [15:0] DUTY_FAR  = 16'd1399;
  localparam logic [15:0] DUTY_OUT  = 16'd2399;

  typedef enum logic [2:0] {
    PH_TRIG_LOW1 = 3'd0,
    PH_TRIG_HIGH = 3'd1,
    PH_TRIG_LOW2 = 3'd2,
    PH_WAIT_ECHO = 3'd3,
    PH_COUNT     = 3'd4,
    PH_GUARD     = 3'd5
  } phase_t;

  // sequencer status toward the rest of the block
  typedef struct packed {
    logic trig;    // trigger drive for this tick
    logic finish;  // measurement completes on this tick
  } seq_stat_t;

  // distance unit result
  typedef struct packed {
    logic [DIST_W-1:0] distance_q8;
    logic              near;
  } dist_res_t;

endpackage

`default_nettype wire

@@ src/ultrasonic_range_pwm_controller_unit.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_range_pwm_controller_unit
// Echo pulse ranging with trigger generation, distance scaling and clamping,
// distance-driven motor PWM and near / far LEDs.
//
//   channel  dir  handshake           payload
//   in_      in   in_valid/in_ready   echo_level, stop_edge (one tick each)
//   out_     out  out_valid/out_ready trigger_out, pwm_out, red_led,
//                                     green_led, distance_valid, distance_q8
//   cfg_     in   cfg_we              cfg_index, cfg_wdata
//
// One tick per cycle sustained while out_ready keeps the result slot draining.
// The input register feeds one pass of sequencer, 16-bit multiplier, clamp and
// duty select into the result register and the state registers.
// A tick leaves the input register only when the result slot is free or
// being taken, so a stalled out_ready holds back at most one further tick.
// Synchronous active-low reset; valid flags, sequencer, PWM state and configuration return to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_range_pwm_controller_unit #(
  parameter int ECHO_COUNT_BITS = urpc_pkg::ECHO_COUNT_BITS_DEF,
  parameter int DUTY_BITS       = urpc_pkg::DUTY_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_echo_level,
  input  wire logic                                in_stop_edge,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_trigger_out,
  output logic                                     out_pwm_out,
  output logic                                     out_red_led,
  output logic                                     out_green_led,
  output logic                                     out_distance_valid,
  output logic [urpc_pkg::DIST_W-1:0]              out_distance_q8,
  input  wire logic                                cfg_we,
  input  wire logic [urpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [urpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [9:0]   trigger_width_r;
  logic [15:0]  guard_wait_r;
  logic [15:0]  scale_q16_r;
  logic [8:0]   min_cm_r;
  logic [8:0]   max_cm_r;
  logic [11:0]  pwm_top_r;

  logic         s1_valid_r, s1_valid_nxt;
  logic         s1_echo_r;
  logic         s1_stop_r;
  logic         out_valid_r, out_valid_nxt;
  logic         out_trig_r;
  logic         out_pwm_r;
  logic         out_dvalid_r;
  logic         adv;
  logic         in_take;

  urpc_pkg::seq_stat_t            seq_stat;
  urpc_pkg::dist_res_t            dist_res;
  logic [ECHO_COUNT_BITS-1:0]     echo_ticks;
  logic [DUTY_BITS-1:0]           dist_duty;
  logic                           pwm;
  logic                           near;
  logic [urpc_pkg::DIST_W-1:0]    distance_q8;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_width_r <= urpc_pkg::TRIGGER_WIDTH_RST;
      guard_wait_r    <= urpc_pkg::GUARD_WAIT_RST;
      scale_q16_r     <= urpc_pkg::SCALE_Q16_RST;
      min_cm_r        <= urpc_pkg::MIN_CM_RST;
      max_cm_r        <= urpc_pkg::MAX_CM_RST;
      pwm_top_r       <= urpc_pkg::PWM_TOP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        urpc_pkg::CFG_TRIGGER_WIDTH: trigger_width_r <= cfg_wdata[9:0];
        urpc_pkg::CFG_GUARD_WAIT:    guard_wait_r    <= cfg_wdata;
        urpc_pkg::CFG_SCALE_Q16:     scale_q16_r     <= cfg_wdata;
        urpc_pkg::CFG_MIN_CM:        min_cm_r        <= cfg_wdata[8:0];
        urpc_pkg::CFG_MAX_CM:        max_cm_r        <= cfg_wdata[8:0];
        urpc_pkg::CFG_PWM_TOP:       pwm_top_r       <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // handshake: a tick advances when the result slot is empty or draining
  always_comb begin
    adv           = s1_valid_r && (!out_valid_r || out_ready);
    in_ready      = !s1_valid_r || adv;
    in_take       = in_valid && in_ready;
    s1_valid_nxt  = in_take || (s1_valid_r && !adv);
    out_valid_nxt = adv || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_echo_r <= in_echo_level;
      s1_stop_r <= in_stop_edge;
    end
    if (adv) begin
      out_trig_r   <= seq_stat.trig;
      out_pwm_r    <= pwm;
      out_dvalid_r <= seq_stat.finish;
    end
  end

  urpc_seq #(
    .ECHO_COUNT_BITS (ECHO_COUNT_BITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .echo          (s1_echo_r),
    .trigger_width (trigger_width_r),
    .guard_wait    (guard_wait_r),
    .stat          (seq_stat),
    .echo_ticks    (echo_ticks)
  );

  urpc_dist #(
    .ECHO_COUNT_BITS (ECHO_COUNT_BITS),
    .DUTY_BITS       (DUTY_BITS)
  ) u_dist (
    .echo_ticks (echo_ticks),
    .scale_q16  (scale_q16_r),
    .min_cm     (min_cm_r),
    .max_cm     (max_cm_r),
    .res        (dist_res),
    .duty       (dist_duty)
  );

  urpc_pwm #(
    .DUTY_BITS (DUTY_BITS)
  ) u_pwm (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .finish      (seq_stat.finish),
    .stop        (s1_stop_r),
    .pwm_top     (pwm_top_r),
    .meas        (dist_res),
    .dist_duty   (dist_duty),
    .pwm         (pwm),
    .near        (near),
    .distance_q8 (distance_q8)
  );

  // led and distance come straight from state that only moves on advance
  assign out_valid          = out_valid_r;
  assign out_trigger_out    = out_trig_r;
  assign out_pwm_out        = out_pwm_r;
  assign out_red_led        = near;
  assign out_green_led      = !near;
  assign out_distance_valid = out_dvalid_r;
  assign out_distance_q8    = distance_q8;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced transaction did not reach the result register");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_distance_q8) && $stable(out_red_led))
    else $error("held result changed while stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |=> s1_valid_r)
    else $error("pending input transaction lost during stall");

endmodule

`default_nettype wire

@@ src/urpc_seq.sv @@
// ----------------------------------------------------------------------------
// urpc_seq
// Trigger / echo / guard phase sequencer with the echo pulse counter.
// ----------------------------------------------------------------------------
`default_nettype none

module urpc_seq #(
  parameter int ECHO_COUNT_BITS = urpc_pkg::ECHO_COUNT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire logic                       echo,
  input  wire logic [9:0]                 trigger_width,
  input  wire logic [15:0]                guard_wait,
  output urpc_pkg::seq_stat_t             stat,
  output logic [ECHO_COUNT_BITS-1:0]      echo_ticks
);

  urpc_pkg::phase_t                phase_r, phase_nxt;
  logic [urpc_pkg::TICK_W-1:0]     ticks_r, ticks_nxt;
  logic [ECHO_COUNT_BITS-1:0]      echo_ticks_r, echo_ticks_nxt;
  logic [urpc_pkg::TICK_W-1:0]     limit;
  logic [urpc_pkg::TICK_W-1:0]     lim;
  logic                            done;

  // limit of the current timed phase, zero counts as one tick
  always_comb begin
    limit = (phase_r == urpc_pkg::PH_GUARD) ? guard_wait : {6'b0, trigger_width};
    lim   = (limit == '0) ? 16'd1 : limit;
    done  = ({1'b0, ticks_r} + 17'd1) >= {1'b0, lim};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= urpc_pkg::PH_TRIG_LOW1;
      ticks_r      <= '0;
      echo_ticks_r <= '0;
    end else if (adv) begin
      phase_r      <= phase_nxt;
      ticks_r      <= ticks_nxt;
      echo_ticks_r <= echo_ticks_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    ticks_nxt      = ticks_r;
    echo_ticks_nxt = echo_ticks_r;
    stat.trig      = (phase_r == urpc_pkg::PH_TRIG_HIGH);
    stat.finish    = 1'b0;
    unique case (phase_r)
      urpc_pkg::PH_TRIG_LOW1,
      urpc_pkg::PH_TRIG_HIGH,
      urpc_pkg::PH_TRIG_LOW2: begin
        if (done) begin
          ticks_nxt = '0;
          unique case (phase_r)
            urpc_pkg::PH_TRIG_LOW1: phase_nxt = urpc_pkg::PH_TRIG_HIGH;
            urpc_pkg::PH_TRIG_HIGH: phase_nxt = urpc_pkg::PH_TRIG_LOW2;
            default:                phase_nxt = urpc_pkg::PH_WAIT_ECHO;
          endcase
        end else begin
          ticks_nxt = ticks_r + 16'd1;
        end
      end
      urpc_pkg::PH_WAIT_ECHO: begin
        if (echo) begin
          echo_ticks_nxt = ECHO_COUNT_BITS'(1);
          phase_nxt      = urpc_pkg::PH_COUNT;
        end
      end
      urpc_pkg::PH_COUNT: begin
        if (echo) begin
          // saturate on very long echoes
          if (!(&echo_ticks_r)) echo_ticks_nxt = echo_ticks_r + ECHO_COUNT_BITS'(1);
        end else begin
          stat.finish = 1'b1;
          phase_nxt   = urpc_pkg::PH_GUARD;
          ticks_nxt   = '0;
        end
      end
      urpc_pkg::PH_GUARD: begin
        if (done) begin
          phase_nxt = urpc_pkg::PH_TRIG_LOW1;
          ticks_nxt = '0;
        end else begin
          ticks_nxt = ticks_r + 16'd1;
        end
      end
      default: begin
        phase_nxt = urpc_pkg::PH_TRIG_LOW1;
        ticks_nxt = '0;
      end
    endcase
  end

  assign echo_ticks = echo_ticks_r;

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == urpc_pkg::PH_COUNT) |-> (echo_ticks_r != '0))
    else $error("echo counter is zero while counting");

  a_finish_to_guard: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stat.finish) |=> (phase_r == urpc_pkg::PH_GUARD) && (ticks_r == '0))
    else $error("finished measurement did not enter guard");

endmodule

`default_nettype wire

@@ src/urpc_dist.sv @@
// ----------------------------------------------------------------------------
// urpc_dist
// Scales the echo count to q8 cm, clamps it and picks the duty and LED flag.
// ----------------------------------------------------------------------------
`default_nettype none

module urpc_dist #(
  parameter int ECHO_COUNT_BITS = urpc_pkg::ECHO_COUNT_BITS_DEF,
  parameter int DUTY_BITS       = urpc_pkg::DUTY_BITS_DEF
) (
  input  wire logic [ECHO_COUNT_BITS-1:0] echo_ticks,
  input  wire logic [15:0]                scale_q16,
  input  wire logic [8:0]                 min_cm,
  input  wire logic [8:0]                 max_cm,
  output urpc_pkg::dist_res_t             res,
  output logic [DUTY_BITS-1:0]            duty
);

  localparam int PROD_W = ECHO_COUNT_BITS + 16;
  localparam int RAW_W  = PROD_W - 8;

  logic [PROD_W-1:0] prod;
  logic [RAW_W-1:0]  raw;
  logic [RAW_W-1:0]  hi;
  logic [RAW_W-1:0]  lo;
  logic [RAW_W-1:0]  lim_hi;
  logic [RAW_W-1:0]  lim_lo;
  logic [15:0]       duty_sel;

  always_comb begin
    prod   = PROD_W'(echo_ticks) * PROD_W'(scale_q16);
    raw    = prod[PROD_W-1:8];
    hi     = RAW_W'({max_cm, 8'b0});
    lo     = RAW_W'({min_cm, 8'b0});
    // upper bound first, so a crossed pair ends at the lower bound
    lim_hi = (raw >= hi) ? hi : raw;
    lim_lo = (lim_hi <= lo) ? lo : lim_hi;
    res.distance_q8 = lim_lo[urpc_pkg::DIST_W-1:0];
    res.near        = (res.distance_q8 <= urpc_pkg::NEAR_Q8);
    priority if (res.distance_q8 <= urpc_pkg::NEAR_Q8) duty_sel = urpc_pkg::DUTY_NEAR;
    else if (res.distance_q8 <= urpc_pkg::MID_Q8)      duty_sel = urpc_pkg::DUTY_MID;
    else if (res.distance_q8 <= urpc_pkg::FAR_Q8)      duty_sel = urpc_pkg::DUTY_FAR;
    else                                               duty_sel = urpc_pkg::DUTY_OUT;
    duty = DUTY_BITS'(duty_sel);
  end

endmodule

`default_nettype wire

@@ src/urpc_pwm.sv @@
// ----------------------------------------------------------------------------
// urpc_pwm
// Motor PWM counter and duty, held distance and proximity flag.
// ----------------------------------------------------------------------------
`default_nettype none

module urpc_pwm #(
  parameter int DUTY_BITS = urpc_pkg::DUTY_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic                        finish,
  input  wire logic                        stop,
  input  wire logic [11:0]                 pwm_top,
  input  wire urpc_pkg::dist_res_t         meas,
  input  wire logic [DUTY_BITS-1:0]        dist_duty,
  output logic                             pwm,
  output logic                             near,
  output logic [urpc_pkg::DIST_W-1:0]      distance_q8
);

  logic [DUTY_BITS-1:0]          count_r, count_nxt;
  logic [DUTY_BITS-1:0]          duty_r, duty_nxt;
  logic                          near_r;
  logic [urpc_pkg::DIST_W-1:0]   dist_r;
  logic [DUTY_BITS+11:0]         top_ext;
  logic [DUTY_BITS-1:0]          top;

  always_comb begin
    top_ext   = (DUTY_BITS + 12)'(pwm_top);
    top       = top_ext[DUTY_BITS-1:0];
    count_nxt = (count_r >= top) ? '0 : count_r + DUTY_BITS'(1);
    duty_nxt  = finish ? dist_duty : duty_r;
    // stop wins over a measurement on the same tick
    if (stop) duty_nxt = '0;
    pwm = (count_r < duty_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      duty_r  <= '0;
      near_r  <= 1'b0;
      dist_r  <= '0;
    end else if (adv) begin
      count_r <= count_nxt;
      duty_r  <= duty_nxt;
      if (finish) begin
        near_r <= meas.near;
        dist_r <= meas.distance_q8;
      end
    end
  end

  assign near        = near_r;
  assign distance_q8 = dist_r;

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ultrasonic_range_pwm_controller_unit. Echo and stop
// ticks are fed through the input channel in random bursts. A cycle-level
// predictor of the ranging sequencer, distance scaling, clamp, duty select and
// pwm counter produces the expected outputs for each tick, and every tick
// result from the unit is checked against them in order. The run steps through
// several register settings, from one-tick trigger phases to crossed clamp
// bounds, and ends with a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import urpc_pkg::*;

  localparam int STALL_LIMIT      = 5000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam logic [15:0] ECHO_SAT = {ECHO_COUNT_BITS_DEF{1'b1}};

  // indexes past the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // receiver ready patterns
  localparam logic [1:0] RX_OPEN   = 2'd0;
  localparam logic [1:0] RX_RANDOM = 2'd1;
  localparam logic [1:0] RX_SPARSE = 2'd2;

  // opening ticks as {echo, stop} pairs, first tick in the top pair
  localparam int          OPEN_LEN = 24;
  localparam logic [47:0] OPENING  =
    48'b10_00_11_00_10_10_01_00_00_00_00_10_00_00_00_00_00_10_11_00_01_10_10_00;

  typedef struct packed {
    logic echo;
    logic stop;
  } tick_in_t;

  typedef struct packed {
    logic              trig;
    logic              pwm;
    logic              red;
    logic              green;
    logic              dvalid;
    logic [DIST_W-1:0] range_q8;
  } ranging_out_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_echo_level = 1'b0;
  logic                  in_stop_edge = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_trigger_out;
  logic                  out_pwm_out;
  logic                  out_red_led;
  logic                  out_green_led;
  logic                  out_distance_valid;
  logic [DIST_W-1:0]     out_distance_q8;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ultrasonic_range_pwm_controller_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_echo_level      (in_echo_level),
    .in_stop_edge       (in_stop_edge),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_trigger_out    (out_trigger_out),
    .out_pwm_out        (out_pwm_out),
    .out_red_led        (out_red_led),
    .out_green_led      (out_green_led),
    .out_distance_valid (out_distance_valid),
    .out_distance_q8    (out_distance_q8),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tick_in_t     stim_ticks[$];
  ranging_out_t tick_outputs_q[$];
  tick_in_t     next_tick;
  ranging_out_t got_out;
  ranging_out_t want_out;
  int           mismatches = 0;
  int           idle_cycles = 0;
  logic         in_taken = 1'b0;
  int           burst_left = 0;
  int           gap_left = 0;
  logic [1:0]   rx_mode = RX_OPEN;
  int           rx_left = 0;
  int           hold_left = 0;
  logic         hold_done = 1'b0;
  logic         start_long_hold = 1'b0;
  int           gen_trig_w = 0;
  int           gen_guard = 0;

  // predictor state and register copies
  phase_t      ph;
  logic [15:0] ph_ticks;
  logic [15:0] echo_cnt;
  logic [16:0] dist_q8;
  logic [11:0] duty;
  logic [11:0] pwm_cnt;
  logic        near;
  logic [9:0]  trig_w_r;
  logic [15:0] guard_r;
  logic [15:0] scale_r;
  logic [8:0]  min_r;
  logic [8:0]  max_r;
  logic [11:0] top_r;

  // advance the predictor by one tick and return that tick's outputs
  function automatic ranging_out_t ranging_tick(logic echo, logic stop);
    ranging_out_t r;
    logic [16:0]  lim;
    logic [31:0]  prod;
    logic [23:0]  raw;
    logic [23:0]  hi_q8;
    logic [23:0]  lo_q8;
    r = '0;
    r.trig = (ph == PH_TRIG_HIGH);
    r.pwm = (pwm_cnt < duty);
    if (pwm_cnt >= top_r) pwm_cnt = '0;
    else pwm_cnt = pwm_cnt + 12'd1;
    case (ph)
      PH_TRIG_LOW1, PH_TRIG_HIGH, PH_TRIG_LOW2: begin
        lim = (trig_w_r == '0) ? 17'd1 : {7'd0, trig_w_r};
        if ({1'b0, ph_ticks} + 17'd1 >= lim) begin
          ph = phase_t'(ph + 3'd1);
          ph_ticks = '0;
        end else begin
          ph_ticks = ph_ticks + 16'd1;
        end
      end
      PH_WAIT_ECHO: begin
        if (echo) begin
          echo_cnt = 16'd1;
          ph = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (echo) begin
          if (echo_cnt != ECHO_SAT) echo_cnt = echo_cnt + 16'd1;
        end else begin
          prod = {16'd0, echo_cnt} * {16'd0, scale_r};
          raw = prod[31:8];
          hi_q8 = {7'd0, max_r, 8'd0};
          lo_q8 = {7'd0, min_r, 8'd0};
          // upper clamp first, so crossed bounds settle on min
          if (raw >= hi_q8) raw = hi_q8;
          if (raw <= lo_q8) raw = lo_q8;
          dist_q8 = raw[16:0];
          if (dist_q8 <= NEAR_Q8) duty = DUTY_NEAR[11:0];
          else if (dist_q8 <= MID_Q8) duty = DUTY_MID[11:0];
          else if (dist_q8 <= FAR_Q8) duty = DUTY_FAR[11:0];
          else duty = DUTY_OUT[11:0];
          near = (dist_q8 <= NEAR_Q8);
          r.dvalid = 1'b1;
          ph = PH_GUARD;
          ph_ticks = '0;
        end
      end
      PH_GUARD: begin
        lim = (guard_r == '0) ? 17'd1 : {1'b0, guard_r};
        if ({1'b0, ph_ticks} + 17'd1 >= lim) begin
          ph = PH_TRIG_LOW1;
          ph_ticks = '0;
        end else begin
          ph_ticks = ph_ticks + 16'd1;
        end
      end
      default: begin
        ph = PH_TRIG_LOW1;
        ph_ticks = '0;
      end
    endcase
    if (stop) duty = '0;
    r.red = near;
    r.green = ~near;
    r.range_q8 = dist_q8;
    return r;
  endfunction

  // monitor: shadow registers, prediction and result check
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
      ph = PH_TRIG_LOW1;
      ph_ticks = '0;
      echo_cnt = '0;
      dist_q8 = '0;
      duty = '0;
      pwm_cnt = '0;
      near = 1'b0;
      trig_w_r = TRIGGER_WIDTH_RST;
      guard_r = GUARD_WAIT_RST;
      scale_r = SCALE_Q16_RST;
      min_r = MIN_CM_RST;
      max_r = MAX_CM_RST;
      top_r = PWM_TOP_RST;
    end else begin
      in_taken <= in_valid && in_ready;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRIGGER_WIDTH: trig_w_r = cfg_wdata[9:0];
          CFG_GUARD_WAIT:    guard_r = cfg_wdata;
          CFG_SCALE_Q16:     scale_r = cfg_wdata;
          CFG_MIN_CM:        min_r = cfg_wdata[8:0];
          CFG_MAX_CM:        max_r = cfg_wdata[8:0];
          CFG_PWM_TOP:       top_r = cfg_wdata[11:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        tick_outputs_q.push_back(ranging_tick(in_echo_level, in_stop_edge));
      if (out_valid && out_ready) begin
        got_out = {out_trigger_out, out_pwm_out, out_red_led, out_green_led,
                   out_distance_valid, out_distance_q8};
        if (tick_outputs_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected tick result at %0t: trig=%b pwm=%b dist=%0d",
                     $time, got_out.trig, got_out.pwm, got_out.range_q8);
          mismatches++;
        end else begin
          want_out = tick_outputs_q.pop_front();
          if (got_out !== want_out) begin
            if (mismatches < 10)
              $display("tick result mismatch at %0t: expected trig=%b pwm=%b red=%b",
                       $time, want_out.trig, want_out.pwm, want_out.red,
                       " green=%b valid=%b dist=%0d", want_out.green, want_out.dvalid,
                       want_out.range_q8,
                       " / got trig=%b pwm=%b red=%b", got_out.trig, got_out.pwm,
                       got_out.red,
                       " green=%b valid=%b dist=%0d", got_out.green, got_out.dvalid,
                       got_out.range_q8);
            mismatches++;
          end
        end
      end
    end
  end

  // driver: one tick per transaction, bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_echo_level <= 1'b0;
      in_stop_edge <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (stim_ticks.size() != 0) begin
        next_tick = stim_ticks.pop_front();
        in_valid <= 1'b1;
        in_echo_level <= next_tick.echo;
        in_stop_edge <= next_tick.stop;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                    : $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: changing ready patterns plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_mode <= RX_OPEN;
      rx_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (start_long_hold && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= 2'($urandom_range(0, 2));
        rx_left <= $urandom_range(16, 160);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
        default:   out_ready <= (rx_left % 4 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // write all six registers, junk in the bits above each register's width
  task automatic load_ranging(logic [9:0] tw, logic [15:0] gw, logic [15:0] sc,
                              logic [8:0] lo_cm, logic [8:0] hi_cm, logic [11:0] top);
    logic [15:0] junk;
    junk = 16'($urandom);
    cfg_write(CFG_TRIGGER_WIDTH, {junk[15:10], tw});
    cfg_write(CFG_GUARD_WAIT, gw);
    cfg_write(CFG_SCALE_Q16, sc);
    cfg_write(CFG_MIN_CM, {junk[15:9], lo_cm});
    cfg_write(CFG_MAX_CM, {junk[15:9], hi_cm});
    cfg_write(CFG_PWM_TOP, {junk[15:12], top});
    gen_trig_w = int'(tw);
    gen_guard = int'(gw);
    @(posedge clk);
  endtask

  task automatic add_tick(logic echo, logic stop);
    stim_ticks.push_back({echo, stop});
  endtask

  task automatic add_ticks(logic echo, int count);
    for (int i = 0; i < count; i++) add_tick(echo, $urandom_range(0, 49) == 0);
  endtask

  // mostly well-formed ranging cycles, some noise and early echoes
  task automatic add_measurements(int runs, int pulse_max);
    int settle;
    int kind;
    int lead;
    int pulse;
    settle = ((gen_guard == 0) ? 1 : gen_guard) + 3 * ((gen_trig_w == 0) ? 1 : gen_trig_w);
    for (int i = 0; i < runs; i++) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        for (int j = $urandom_range(1, 12); j > 0; j--)
          add_tick(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
      end
      lead = (kind == 1) ? $urandom_range(0, settle) : settle + $urandom_range(0, 3);
      pulse = $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(1, pulse_max);
      add_ticks(1'b0, lead);
      add_ticks(1'b1, pulse);
    end
    add_ticks(1'b0, 2);
  endtask

  // sender holds back until the unit has returned every tick result
  task automatic drain_results();
    logic busy;
    busy = 1'b1;
    while (busy) begin
      @(posedge clk);
      busy = (stim_ticks.size() != 0) || in_valid;
      @(negedge clk);
      busy = busy || (tick_outputs_q.size() != 0);
    end
  endtask

  initial begin : stimulus
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // one-tick phases, full-scale echo
    load_ranging(10'd0, 16'd0, 16'hFFFF, 9'd0, 9'd511, 12'd0);
    cfg_write(CFG_SPARE_LO, 16'($urandom));
    cfg_write(CFG_SPARE_HI, 16'($urandom));
    @(posedge clk);
    for (int i = OPEN_LEN - 1; i >= 0; i--) add_tick(OPENING[2*i+1], OPENING[2*i]);
    drain_results();

    load_ranging(10'd1, 16'd0, 16'hFFFF, 9'd0, 9'd511, 12'd4095);
    add_measurements(4, 230);
    drain_results();

    load_ranging(10'd3, 16'd5, 16'($urandom_range(30000, 65535)), 9'd2, 9'd400,
                 12'd2399);
    add_measurements(3, 230);
    drain_results();

    // crossed clamp bounds
    load_ranging(10'd1, 16'd1, 16'hFFFF, 9'd150, 9'd60, 12'd1000);
    add_measurements(3, 120);
    drain_results();

    load_ranging(10'd0, 16'd0, 16'd0, 9'd0, 9'd511, 12'd1);
    add_measurements(3, 60);
    drain_results();

    load_ranging(10'd2, 16'd2, 16'd1, 9'd511, 9'd511, 12'd4095);
    add_measurements(2, 60);
    drain_results();

    // pwm counter left high by the last setting must wrap
    load_ranging(10'd1, 16'd0, 16'hFFFF, 9'd0, 9'd300, 12'd7);
    cfg_write(CFG_SPARE_HI, 16'($urandom));
    @(posedge clk);
    add_measurements(2, 230);
    drain_results();

    for (int k = 0; k < 4; k++) begin
      load_ranging(10'($urandom_range(0, 8)), 16'($urandom_range(0, 24)),
                   16'($urandom_range(0, 65535)),
                   9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                   12'($urandom_range(0, 4095)));
      add_measurements(2, 60);
      drain_results();
    end

    // long receiver hold while the sender keeps offering ticks
    load_ranging(10'd2, 16'd4, 16'd40000, 9'd2, 9'd400, 12'd2399);
    start_long_hold = 1'b1;
    add_measurements(2, 60);
    drain_results();

    repeat (8) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && tick_outputs_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/urpc_pkg.sv
src/urpc_seq.sv
src/urpc_dist.sv
src/urpc_pwm.sv
src/ultrasonic_range_pwm_controller_unit.sv
test/tb.sv
